// ===== rtl/pit_pkg.sv =====
// Package for the periodic interval timer array.
// Command codes, field widths and the control/status structs between controller and datapath.
// No dependencies.
package pit_pkg;

	localparam int NUM_TIMERS_DEF = 8;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 8;
	localparam int IVL_W  = 16;
	localparam int TICK_W = 8;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd3;

	typedef struct packed {
		logic load;
		logic walk_rd;
		logic finish;
	} pit_ctl_t;

	typedef struct packed {
		logic is_walk;
		logic last;
	} pit_sts_t;

endpackage

// ===== rtl/pit_ctrl.sv =====
// Controller state machine of the periodic interval timer array.
// Sequences accept, timer walk and result handoff. Depends on pit_pkg.
module pit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  pit_pkg::pit_sts_t sts,
	output pit_pkg::pit_ctl_t ctl
);
	import pit_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nx    = state_q;
		ctl.load    = 1'b0;
		ctl.walk_rd = 1'b0;
		ctl.finish  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				if (sts.is_walk) begin
					ctl.walk_rd = 1'b1;
					if (sts.last)
						state_nx = S_DRAIN;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_DRAIN: state_nx = S_FIN;
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctl.finish = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == S_RUN && !cmd_ready)
		else $error("accept did not start processing");
	a_last_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_rd && sts.last |=> state_q == S_DRAIN)
		else $error("walk did not end after last timer");

endmodule

// ===== rtl/pit_dp.sv =====
// Datapath of the periodic interval timer array.
// Item register, period/remaining memory, run and expiry bits, walk pointer, result register.
// Depends on pit_pkg.
module pit_dp #(
	parameter int NUM_TIMERS = pit_pkg::NUM_TIMERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pit_pkg::CMD_W-1:0]   command,
	input  logic [pit_pkg::IDX_W-1:0]   index,
	input  logic [pit_pkg::IVL_W-1:0]   interval,
	input  logic [pit_pkg::TICK_W-1:0]  tick_count,
	input  pit_pkg::pit_ctl_t           ctl,
	output pit_pkg::pit_sts_t           sts,
	output logic                        expired
);
	import pit_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int DW = 2 * IVL_W;

	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IVL_W-1:0]  ivl_q;
	logic [TICK_W-1:0] tcnt_q;

	logic [DW-1:0]     mem [NUM_TIMERS];
	logic [DW-1:0]     rdata_s1;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW-1:0]     wr_ptr_s1;
	logic              rd_vld_s1;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] flag_q;
	logic              exp_q;

	logic              in_range;
	logic [AW-1:0]     slot;
	logic [IVL_W-1:0]  per_s1;
	logic [IVL_W-1:0]  rem_s1;
	logic              hit_s1;
	logic              walk_we;
	logic              start_we;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [DW-1:0]     mem_wd;

	assign in_range = idx_q < IDX_W'(NUM_TIMERS);
	assign slot     = idx_q[AW-1:0];
	assign per_s1   = rdata_s1[DW-1:IVL_W];
	assign rem_s1   = rdata_s1[IVL_W-1:0];
	assign hit_s1   = rem_s1 <= {{(IVL_W-TICK_W){1'b0}}, tcnt_q};
	assign walk_we  = rd_vld_s1 && run_q[wr_ptr_s1];
	assign start_we = ctl.finish && cmd_q == CMD_START && in_range;
	assign mem_we   = walk_we || start_we;

	always_comb begin
		if (walk_we) begin
			mem_wa = wr_ptr_s1;
			mem_wd = hit_s1 ? {per_s1, per_s1}
			                : {per_s1, rem_s1 - {{(IVL_W-TICK_W){1'b0}}, tcnt_q}};
		end else begin
			mem_wa = slot;
			mem_wd = {ivl_q, ivl_q};
		end
	end

	assign sts.is_walk = cmd_q == CMD_TICK && tcnt_q != '0;
	assign sts.last    = rd_ptr_q == AW'(NUM_TIMERS - 1);
	assign expired     = exp_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			idx_q  <= index;
			ivl_q  <= interval;
			tcnt_q <= tick_count;
		end
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (ctl.walk_rd) begin
			rdata_s1  <= mem[rd_ptr_q];
			wr_ptr_s1 <= rd_ptr_q;
		end
		if (ctl.finish)
			exp_q <= cmd_q == CMD_CHECK && in_range && flag_q[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			run_q     <= '0;
			flag_q    <= '0;
		end else begin
			rd_vld_s1 <= ctl.walk_rd;
			if (ctl.load)
				rd_ptr_q <= '0;
			else if (ctl.walk_rd)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (walk_we && hit_s1)
				flag_q[wr_ptr_s1] <= 1'b1;
			if (ctl.finish && in_range) begin
				case (cmd_q)
					CMD_START: begin
						run_q[slot]  <= ivl_q != '0;
						flag_q[slot] <= 1'b0;
					end
					CMD_STOP:  run_q[slot]  <= 1'b0;
					CMD_CHECK: flag_q[slot] <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_rd |-> rd_ptr_q <= AW'(NUM_TIMERS - 1))
		else $error("walk pointer past last timer");
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !rd_vld_s1)
		else $error("command update overlaps walk write-back");

endmodule

// ===== rtl/periodic_interval_timer_array.sv =====
// Top level of the periodic interval timer array: controller plus datapath.
// Depends on pit_pkg, pit_ctrl and pit_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  cmd     | cmd_valid / cmd_ready | command, index, interval, tick_count
//  rsp     | rsp_valid / rsp_ready | expired
//
// A tick with nonzero tick_count walks the timers one per cycle through the single memory
// read port, then the drain state waits for the last write-back before the result is
// handed off. Start, stop, check and zero ticks skip the walk.
// Reset clears run and expiry bits at once; the memory needs no clearing pass.
// A result held in the output register stalls only the completion of the next transaction.
module periodic_interval_timer_array #(
	parameter int NUM_TIMERS = pit_pkg::NUM_TIMERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [pit_pkg::CMD_W-1:0]   command,
	input  logic [pit_pkg::IDX_W-1:0]   index,
	input  logic [pit_pkg::IVL_W-1:0]   interval,
	input  logic [pit_pkg::TICK_W-1:0]  tick_count,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        expired
);
	import pit_pkg::*;

	pit_ctl_t ctl;
	pit_sts_t sts;

	pit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pit_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.index      (index),
		.interval   (interval),
		.tick_count (tick_count),
		.ctl        (ctl),
		.sts        (sts),
		.expired    (expired)
	);

endmodule

// ===== tb/pit_expiry_checker.sv =====
// Checker for the periodic interval timer array: watches the cmd and rsp channels.
// Keeps its own timer state, queues the expected expired bit per transaction and compares.
// Depends on pit_pkg.
module pit_expiry_checker #(
	parameter int NUM_TIMERS = pit_pkg::NUM_TIMERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  logic                        cmd_ready,
	input  logic [pit_pkg::CMD_W-1:0]   command,
	input  logic [pit_pkg::IDX_W-1:0]   index,
	input  logic [pit_pkg::IVL_W-1:0]   interval,
	input  logic [pit_pkg::TICK_W-1:0]  tick_count,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic                        expired,
	output int                          fail_count,
	output int                          outstanding,
	output int                          cmd_seen,
	output int                          flags_reported
);
	import pit_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [IVL_W-1:0] timer_period [NUM_TIMERS];
	logic [IVL_W-1:0] timer_left   [NUM_TIMERS];
	logic             timer_flag   [NUM_TIMERS];
	logic             expiry_q [$];
	logic             want;
	int               errors;
	int               n_cmd;
	int               n_flag;

	function automatic logic run_timer_cmd(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [IVL_W-1:0] ivl,
			input logic [TICK_W-1:0] ticks);
		logic hit;
		logic flag_out;
		logic [AW-1:0] slot;
		hit = idx < NUM_TIMERS;
		slot = idx[AW-1:0];
		flag_out = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (ticks != '0) begin
					for (int t = 0; t < NUM_TIMERS; t++) begin
						if (timer_period[t] != '0) begin
							if (timer_left[t] <= {8'd0, ticks}) begin
								timer_left[t] = timer_period[t];
								timer_flag[t] = 1'b1;
							end else begin
								timer_left[t] = timer_left[t] - {8'd0, ticks};
							end
						end
					end
				end
			end
			CMD_START: begin
				if (hit) begin
					timer_flag[slot] = 1'b0;
					timer_left[slot] = ivl;
					timer_period[slot] = ivl;
				end
			end
			CMD_STOP: begin
				if (hit)
					timer_period[slot] = '0;
			end
			CMD_CHECK: begin
				if (hit && timer_flag[slot]) begin
					timer_flag[slot] = 1'b0;
					flag_out = 1'b1;
				end
			end
			default: ;
		endcase
		return flag_out;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				timer_period[t] = '0;
				timer_left[t] = '0;
				timer_flag[t] = 1'b0;
			end
			expiry_q.delete();
			errors = 0;
			n_cmd = 0;
			n_flag = 0;
			fail_count <= 0;
			outstanding <= 0;
			cmd_seen <= 0;
			flags_reported <= 0;
		end else begin
			// result first: it always belongs to an earlier transaction
			if (rsp_valid && rsp_ready) begin
				if (expiry_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual expired=%b",
						$time, expired);
					errors++;
				end else begin
					want = expiry_q.pop_front();
					if (expired !== want) begin
						$display("%0t: expired mismatch, expected %b, actual %b",
							$time, want, expired);
						errors++;
					end
					if (want)
						n_flag++;
				end
			end
			if (cmd_valid && cmd_ready) begin
				expiry_q.push_back(run_timer_cmd(command, index, interval, tick_count));
				n_cmd++;
			end
			fail_count <= errors;
			outstanding <= expiry_q.size();
			cmd_seen <= n_cmd;
			flags_reported <= n_flag;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the periodic interval timer array: clock, reset, stimulus and verdict.
// Directed transactions, then random ones under four idle/stall phases.
// Depends on pit_pkg, periodic_interval_timer_array and pit_expiry_checker.
module tb_top;
	import pit_pkg::*;

	localparam int NT         = NUM_TIMERS_DEF;
	localparam int PHASE_ITEMS = 260;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	logic [CMD_W-1:0]  command = CMD_TICK;
	logic [IDX_W-1:0]  index = '0;
	logic [IVL_W-1:0]  interval = '0;
	logic [TICK_W-1:0] tick_count = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic              expired;

	int fail_count;
	int outstanding;
	int cmd_seen;
	int flags_reported;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int cycles = 0;

	periodic_interval_timer_array #(.NUM_TIMERS(NT)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.index      (index),
		.interval   (interval),
		.tick_count (tick_count),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.expired    (expired)
	);

	pit_expiry_checker #(.NUM_TIMERS(NT)) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.command        (command),
		.index          (index),
		.interval       (interval),
		.tick_count     (tick_count),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.expired        (expired),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.cmd_seen       (cmd_seen),
		.flags_reported (flags_reported)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycles, outstanding);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called at a clock edge; returns at the edge that accepts the transaction
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] i,
			input logic [IVL_W-1:0] v, input logic [TICK_W-1:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid  <= 1'b1;
		command    <= c;
		index      <= i;
		interval   <= v;
		tick_count <= t;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic wait_results_drained();
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_random_cmd();
		logic [CMD_W-1:0]  c;
		logic [IDX_W-1:0]  i;
		logic [IVL_W-1:0]  v;
		logic [TICK_W-1:0] t;
		int r;
		r = $urandom_range(99);
		if (r < 35)
			c = CMD_TICK;
		else if (r < 55)
			c = CMD_START;
		else if (r < 65)
			c = CMD_STOP;
		else
			c = CMD_CHECK;
		i = ($urandom_range(99) < 90) ? IDX_W'($urandom_range(NT - 1)) : IDX_W'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 8)
			v = '0;
		else if (r < 16)
			v = '1;
		else if (r < 30)
			v = IVL_W'($urandom);
		else
			v = IVL_W'($urandom_range(400, 1));
		r = $urandom_range(99);
		if (r < 6)
			t = '0;
		else if (r < 14)
			t = '1;
		else if (r < 24)
			t = TICK_W'($urandom_range(255));
		else
			t = TICK_W'($urandom_range(40, 1));
		send_cmd(c, i, v, t);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_CHECK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_START, 8'd0, 16'd1, 8'd0);
		send_cmd(CMD_START, 8'd7, 16'hFFFF, 8'hFF);
		send_cmd(CMD_START, 8'd3, 16'd0, 8'd0);
		send_cmd(CMD_START, 8'd255, 16'hFFFF, 8'hFF);
		send_cmd(CMD_TICK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_CHECK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_TICK, 8'd5, 16'hFFFF, 8'd1);
		send_cmd(CMD_CHECK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_CHECK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_TICK, 8'd0, 16'd0, 8'hFF);
		send_cmd(CMD_CHECK, 8'd7, 16'd0, 8'd0);
		send_cmd(CMD_CHECK, 8'd3, 16'd0, 8'd0);
		send_cmd(CMD_STOP, 8'd0, 16'hFFFF, 8'hFF);
		send_cmd(CMD_TICK, 8'd255, 16'd0, 8'hFF);
		send_cmd(CMD_CHECK, 8'd0, 16'd0, 8'd0);
		send_cmd(CMD_STOP, 8'd8, 16'd0, 8'd0);
		send_cmd(CMD_CHECK, 8'd8, 16'd0, 8'd0);
		send_cmd(CMD_CHECK, 8'd255, 16'hFFFF, 8'hFF);
		send_cmd(CMD_START, 8'd2, 16'd256, 8'd0);
		send_cmd(CMD_TICK, 8'd0, 16'd0, 8'hFF);
		send_cmd(CMD_TICK, 8'd0, 16'd0, 8'd1);
		send_cmd(CMD_CHECK, 8'd2, 16'd0, 8'd0);
		send_cmd(CMD_START, 8'd7, 16'd2, 8'd0);
		send_cmd(CMD_CHECK, 8'd7, 16'd0, 8'd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
				1: begin send_idle_pct = 76; rsp_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct <= 76; end
				default: begin send_idle_pct = 26; rsp_stall_pct <= 26; end
			endcase
			repeat (PHASE_ITEMS) send_random_cmd();
			// hold the sender until every result is back
			cmd_valid <= 1'b0;
			wait_results_drained();
		end

		cmd_valid <= 1'b0;
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d timer transactions: directed corner cases, then random ones",
			cmd_seen);
		$display("under four idle/stall phases; %0d checks returned an expired flag.",
			flags_reported);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
